// ----- hw/rtl/pidt_pkg.sv -----
`default_nettype none

package pidt_pkg;

	// Number of external interrupt lines, one debounce timestamp each.
	localparam int unsigned LINE_COUNT = 16;
	// Upper bound on dispatch results caused by one line event.
	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned EMIT_W = 5;

	typedef enum logic [1:0] {
		CMD_REGISTER   = 2'd0,
		CMD_UNREGISTER = 2'd1,
		CMD_ENABLE     = 2'd2,
		CMD_EVENT      = 2'd3
	} cmd_t;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_PARAM_ERR  = 2'd1;
	localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

	localparam logic KIND_STATUS   = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EV_CHECK,
		ST_SCAN,
		ST_UNREG_RD,
		ST_UNREG_WR,
		ST_STATUS
	} state_t;

	typedef struct packed {
		logic [3:0]  port;
		logic [15:0] mask;
		logic [7:0]  handler;
		logic        enabled;
	} entry_t;

	typedef struct packed {
		logic hit;
		logic level;
	} match_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] status;
		logic [3:0] port;
		logic [3:0] line;
		logic       level;
		logic [7:0] handler;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pidt_table.sv -----
`default_nettype none

// Registration table storage: one write port, one read port with registered data.
module pidt_table
	import pidt_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire                                      clk,
	input  wire                                      wr_en,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  entry_t                                   wr_data,
	input  wire                                      rd_en,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output entry_t                                   rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pidt_match.sv -----
`default_nettype none

// Shared compare unit used by every table scan.
module pidt_match
	import pidt_pkg::*;
(
	input  entry_t      entry,
	input  wire         is_event,
	input  wire  [3:0]  key_port,
	input  wire  [15:0] key_mask,
	input  wire  [15:0] levels,
	output match_t      result
);

	always_comb begin
		if (is_event) begin
			// An event matches an enabled entry whose mask is exactly the line's pin.
			result.hit = (entry.mask == key_mask) && entry.enabled;
		end else begin
			result.hit = (entry.port == key_port) && (entry.mask == key_mask);
		end
		result.level = levels[entry.port];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pin_interrupt_dispatch_table.sv -----
// Pin interrupt dispatch table.
// Requests enter on the in_valid/in_stall channel; one request is taken at a time and
// in_stall stays high until the request has been fully worked off. Table requests
// (register, unregister, set enable) always return exactly one status result; a line
// event returns one dispatch result per enabled entry registered on that line's pin,
// in table order, with last marking the final one, or nothing when it is debounced
// or nothing matches. Results leave through a one-deep output register on the
// out_valid/out_stall channel, so the next request is taken while a result waits.
// A request walks the table one entry per clock through a single compare unit fed
// by the table's read port; an unregister that finds its entry then moves the last
// entry into the freed slot. A stalled receiver holds the scan only when a further
// dispatch must be handed on. Reset empties the table, clears every line's debounce
// timestamp to zero and loads a debounce window of 20 ms. cfg_wr_en writes a new
// window; the user must write it only while the block is idle, which the block
// itself does not enforce.
`default_nettype none

module pin_interrupt_dispatch_table
	import pidt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned PORT_COUNT  = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [15:0] cfg_wr_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  cmd,
	input  wire  [3:0]  port_id,
	input  wire  [15:0] pin_bits,
	input  wire  [7:0]  handler_id,
	input  wire         enable_flag,
	input  wire  [3:0]  line,
	input  wire  [31:0] now_ms,
	input  wire  [15:0] line_levels,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        kind,
	output logic [1:0]  status,
	output logic [3:0]  out_port,
	output logic [3:0]  out_line,
	output logic        pin_level,
	output logic [7:0]  out_handler,
	output logic        last
);

	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// Sequencer state and scan bookkeeping.
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
	logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
	logic              cmp_vld_q, cmp_vld_d;
	logic              pend_vld_q, pend_vld_d;
	result_t           pend_q, pend_d;
	logic [EMIT_W-1:0] emit_cnt_q, emit_cnt_d;
	logic [1:0]        status_q, status_d;

	// Captured request.
	cmd_t        cmd_q;
	logic [3:0]  port_q;
	logic [15:0] mask_q;
	logic [7:0]  handler_q;
	logic        enable_q;
	logic [3:0]  line_q;
	logic [31:0] now_q;
	logic [15:0] levels_q;

	logic [15:0] window_q;
	logic [31:0] last_ms_q [LINE_COUNT];

	logic    out_valid_q;
	result_t out_q;
	logic    out_load;
	result_t out_new;

	// Table port and compare unit.
	logic             rd_en, wr_en, last_wr;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	entry_t           rd_data, wr_data;
	match_t           match;

	logic             in_acc, out_can_load, issue, ev_hit, ev_block, cmd_hit, scan_end;
	logic             args_bad, reg_bad;
	logic [CNT_W-1:0] tail_idx;
	logic [15:0]      ev_pin;
	logic [31:0]      elapsed;

	assign in_stall     = (state_q != ST_IDLE);
	assign in_acc       = in_valid && !in_stall;
	assign out_can_load = !out_valid_q || !out_stall;

	assign ev_pin   = 16'(1) << line_q;
	assign elapsed  = now_q - last_ms_q[line_q];
	assign tail_idx = count_q - CNT_W'(1);

	assign issue    = (rd_idx_q < count_q);
	assign scan_end = !cmp_vld_q && !issue;
	assign ev_hit   = cmp_vld_q && match.hit && (emit_cnt_q < EMIT_W'(MAX_RESULTS));
	// A second hit needs the output register to take the one already pending.
	assign ev_block = ev_hit && pend_vld_q && !out_can_load;
	assign cmd_hit  = cmp_vld_q && match.hit;

	assign args_bad = ({1'b0, port_id} >= 5'(PORT_COUNT)) || (pin_bits == 16'd0);
	assign reg_bad  = (handler_id == 8'd0) || ((pin_bits & (pin_bits - 16'd1)) != 16'd0);

	pidt_table #(
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pidt_match u_match (
		.entry    (rd_data),
		.is_event (cmd_q == CMD_EVENT),
		.key_port (port_q),
		.key_mask ((cmd_q == CMD_EVENT) ? ev_pin : mask_q),
		.levels   (levels_q),
		.result   (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			cmp_vld_q   <= 1'b0;
			pend_vld_q  <= 1'b0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			window_q    <= 16'd20;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_idx_q    <= rd_idx_d;
			cmp_vld_q   <= cmp_vld_d;
			pend_vld_q  <= pend_vld_d;
			emit_cnt_q  <= emit_cnt_d;
			out_valid_q <= out_load || (out_valid_q && out_stall);
			if (cfg_wr_en) begin
				window_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINE_COUNT; i++) begin
				last_ms_q[i] <= '0;
			end
		end else if (last_wr) begin
			last_ms_q[line_q] <= now_q;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_q <= cmp_idx_d;
		pend_q    <= pend_d;
		status_q  <= status_d;
		if (out_load) begin
			out_q <= out_new;
		end
		if (in_acc) begin
			cmd_q     <= cmd_t'(cmd);
			port_q    <= port_id;
			mask_q    <= pin_bits;
			handler_q <= handler_id;
			enable_q  <= enable_flag;
			line_q    <= line;
			now_q     <= now_ms;
			levels_q  <= line_levels;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rd_idx_d   = rd_idx_q;
		cmp_idx_d  = cmp_idx_q;
		cmp_vld_d  = cmp_vld_q;
		pend_vld_d = pend_vld_q;
		pend_d     = pend_q;
		emit_cnt_d = emit_cnt_q;
		status_d   = status_q;
		rd_en      = 1'b0;
		rd_addr    = rd_idx_q[IDX_W-1:0];
		wr_en      = 1'b0;
		wr_addr    = cmp_idx_q;
		wr_data    = rd_data;
		last_wr    = 1'b0;
		out_load   = 1'b0;
		out_new    = pend_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					rd_idx_d   = '0;
					cmp_vld_d  = 1'b0;
					pend_vld_d = 1'b0;
					emit_cnt_d = '0;
					status_d   = STATUS_OK;
					if (cmd_t'(cmd) == CMD_EVENT) begin
						state_d = ST_EV_CHECK;
					end else if (args_bad || ((cmd_t'(cmd) == CMD_REGISTER) && reg_bad)) begin
						status_d = STATUS_PARAM_ERR;
						state_d  = ST_STATUS;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end

			ST_EV_CHECK: begin
				// Events inside the debounce window of the line's last accepted event
				// are dropped without any result.
				if (elapsed < {16'd0, window_q}) begin
					state_d = ST_IDLE;
				end else begin
					last_wr = 1'b1;
					state_d = ST_SCAN;
				end
			end

			ST_SCAN: begin
				if (cmd_q == CMD_EVENT) begin
					if (scan_end) begin
						if (!pend_vld_q) begin
							state_d = ST_IDLE;
						end else if (out_can_load) begin
							out_load      = 1'b1;
							out_new.last  = 1'b1;
							pend_vld_d    = 1'b0;
							state_d       = ST_IDLE;
						end
					end else if (!ev_block) begin
						rd_en     = issue;
						cmp_vld_d = issue;
						cmp_idx_d = rd_idx_q[IDX_W-1:0];
						if (issue) begin
							rd_idx_d = rd_idx_q + CNT_W'(1);
						end
						if (ev_hit) begin
							// The previous hit is known not to be the final one now.
							out_load       = pend_vld_q;
							pend_vld_d     = 1'b1;
							emit_cnt_d     = emit_cnt_q + EMIT_W'(1);
							pend_d.kind    = KIND_DISPATCH;
							pend_d.status  = STATUS_OK;
							pend_d.port    = rd_data.port;
							pend_d.line    = line_q;
							pend_d.level   = match.level;
							pend_d.handler = rd_data.handler;
							pend_d.last    = 1'b0;
						end
					end
				end else if (cmd_hit) begin
					// The matching entry stays in the read register while we act on it.
					priority if (cmd_q == CMD_REGISTER) begin
						wr_en           = 1'b1;
						wr_data.port    = port_q;
						wr_data.mask    = mask_q;
						wr_data.handler = handler_q;
						wr_data.enabled = 1'b1;
						state_d         = ST_STATUS;
					end else if (cmd_q == CMD_ENABLE) begin
						wr_en           = 1'b1;
						wr_data.enabled = enable_q;
						state_d         = ST_STATUS;
					end else begin
						state_d = ST_UNREG_RD;
					end
				end else if (scan_end) begin
					// Not found: only a registration changes the table.
					if (cmd_q == CMD_REGISTER) begin
						if (count_q >= CNT_W'(TABLE_DEPTH)) begin
							status_d = STATUS_TABLE_FULL;
						end else begin
							wr_en           = 1'b1;
							wr_addr         = count_q[IDX_W-1:0];
							wr_data.port    = port_q;
							wr_data.mask    = mask_q;
							wr_data.handler = handler_q;
							wr_data.enabled = 1'b1;
							count_d         = count_q + CNT_W'(1);
						end
					end
					state_d = ST_STATUS;
				end else begin
					rd_en     = issue;
					cmp_vld_d = issue;
					cmp_idx_d = rd_idx_q[IDX_W-1:0];
					if (issue) begin
						rd_idx_d = rd_idx_q + CNT_W'(1);
					end
				end
			end

			ST_UNREG_RD: begin
				// Fetch the last entry so that it can fill the freed slot.
				rd_en   = 1'b1;
				rd_addr = tail_idx[IDX_W-1:0];
				state_d = ST_UNREG_WR;
			end

			ST_UNREG_WR: begin
				wr_en   = 1'b1;
				count_d = tail_idx;
				state_d = ST_STATUS;
			end

			ST_STATUS: begin
				if (out_can_load) begin
					out_load       = 1'b1;
					out_new        = '0;
					out_new.kind   = KIND_STATUS;
					out_new.status = status_q;
					out_new.last   = 1'b1;
					state_d        = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign status      = out_q.status;
	assign out_port    = out_q.port;
	assign out_line    = out_q.line;
	assign pin_level   = out_q.level;
	assign out_handler = out_q.handler;
	assign last        = out_q.last;

endmodule

`default_nettype wire

// ----- dv/dispatch_table_checker.sv -----
module dispatch_table_checker
	import pidt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned PORT_COUNT  = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [15:0] cfg_wr_data,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [1:0]  cmd,
	input  wire  [3:0]  port_id,
	input  wire  [15:0] pin_bits,
	input  wire  [7:0]  handler_id,
	input  wire         enable_flag,
	input  wire  [3:0]  line,
	input  wire  [31:0] now_ms,
	input  wire  [15:0] line_levels,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire         kind,
	input  wire  [1:0]  status,
	input  wire  [3:0]  out_port,
	input  wire  [3:0]  out_line,
	input  wire         pin_level,
	input  wire  [7:0]  out_handler,
	input  wire         last,
	output int          mismatches,
	output int          owed,
	output int          status_seen,
	output int          dispatch_seen
);

	logic [15:0] window;
	logic [3:0]  slot_port    [TABLE_DEPTH];
	logic [15:0] slot_mask    [TABLE_DEPTH];
	logic [7:0]  slot_handler [TABLE_DEPTH];
	logic        slot_enabled [TABLE_DEPTH];
	int          slot_count;
	logic [31:0] line_stamp   [LINE_COUNT];
	result_t     owed_results [$];
	int          bad = 0;
	int          n_status = 0;
	int          n_dispatch = 0;

	function automatic int find_slot(input logic [3:0] p, input logic [15:0] m);
		for (int i = 0; i < slot_count; i++) begin
			if (slot_port[i] == p && slot_mask[i] == m)
				return i;
		end
		return slot_count;
	endfunction

	// Updates the shadow table and queues whatever results one request causes.
	function automatic void apply_request(input cmd_t c, input logic [3:0] p,
			input logic [15:0] m, input logic [7:0] h, input logic en,
			input logic [3:0] ln, input logic [31:0] t, input logic [15:0] lv);
		result_t     r;
		logic [15:0] pin;
		logic [31:0] age;
		int          idx;
		int          first;
		int          tail;
		r = '0;
		if (c == CMD_EVENT) begin
			pin = 16'd1 << ln;
			age = t - line_stamp[ln];
			if (age < {16'd0, window})
				return;
			line_stamp[ln] = t;
			first = owed_results.size();
			for (int i = 0; i < slot_count; i++) begin
				if (slot_mask[i] == pin && slot_enabled[i]) begin
					r.kind = KIND_DISPATCH;
					r.port = slot_port[i];
					r.line = ln;
					r.level = lv[slot_port[i]];
					r.handler = slot_handler[i];
					r.last = 1'b0;
					owed_results.push_back(r);
				end
			end
			if (owed_results.size() > first)
				owed_results[owed_results.size() - 1].last = 1'b1;
			return;
		end
		r.kind = KIND_STATUS;
		r.status = STATUS_OK;
		r.last = 1'b1;
		idx = find_slot(p, m);
		if (p >= PORT_COUNT || m == '0) begin
			r.status = STATUS_PARAM_ERR;
		end else if (c == CMD_REGISTER) begin
			if (h == '0 || (m & (m - 16'd1)) != '0) begin
				r.status = STATUS_PARAM_ERR;
			end else if (idx < slot_count) begin
				slot_handler[idx] = h;
				slot_enabled[idx] = 1'b1;
			end else if (slot_count >= TABLE_DEPTH) begin
				r.status = STATUS_TABLE_FULL;
			end else begin
				slot_port[slot_count] = p;
				slot_mask[slot_count] = m;
				slot_handler[slot_count] = h;
				slot_enabled[slot_count] = 1'b1;
				slot_count++;
			end
		end else if (c == CMD_UNREGISTER) begin
			if (idx < slot_count) begin
				tail = slot_count - 1;
				slot_port[idx] = slot_port[tail];
				slot_mask[idx] = slot_mask[tail];
				slot_handler[idx] = slot_handler[tail];
				slot_enabled[idx] = slot_enabled[tail];
				slot_port[tail] = '0;
				slot_mask[tail] = '0;
				slot_handler[tail] = '0;
				slot_enabled[tail] = 1'b0;
				slot_count = tail;
			end
		end else if (idx < slot_count) begin
			slot_enabled[idx] = en;
		end
		owed_results.push_back(r);
	endfunction

	task automatic report(input string what, input result_t want, input result_t got);
		bad++;
		if (bad <= 10) begin
			$display("%0t %s: expected kind %0d status %0d port %0d line %0d level %0d",
				$time, what, want.kind, want.status, want.port, want.line, want.level);
			$display("    handler %0d last %0d, got kind %0d status %0d port %0d",
				want.handler, want.last, got.kind, got.status, got.port);
			$display("    line %0d level %0d handler %0d last %0d",
				got.line, got.level, got.handler, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			window = 16'd20;
			slot_count = 0;
			for (int i = 0; i < LINE_COUNT; i++)
				line_stamp[i] = '0;
			owed_results.delete();
		end else begin
			// Results leave first: nothing accepted at this edge can already be on the output.
			if (out_valid && !out_stall) begin
				got = {kind, status, out_port, out_line, pin_level, out_handler, last};
				if (owed_results.size() == 0) begin
					report("result with nothing outstanding", '0, got);
				end else begin
					want = owed_results.pop_front();
					if (got.kind !== want.kind || got.status !== want.status ||
							got.port !== want.port || got.line !== want.line ||
							got.level !== want.level || got.handler !== want.handler ||
							got.last !== want.last)
						report("result differs", want, got);
				end
				if (got.kind == KIND_DISPATCH)
					n_dispatch++;
				else
					n_status++;
			end
			if (cfg_wr_en)
				window = cfg_wr_data;
			if (in_valid && !in_stall)
				apply_request(cmd_t'(cmd), port_id, pin_bits, handler_id, enable_flag,
					line, now_ms, line_levels);
		end
		mismatches <= bad;
		owed <= owed_results.size();
		status_seen <= n_status;
		dispatch_seen <= n_dispatch;
	end

endmodule

// ----- dv/tb_pin_interrupt_dispatch_table.sv -----
// Top of the dispatch table testbench. This module only produces stimulus and
// gives the verdict; the checker instance beside the block watches both channels,
// keeps its own copy of the table and the debounce stamps, and counts failures.
module tb_pin_interrupt_dispatch_table;
	import pidt_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_REGISTER;
	logic [3:0]  port_id = '0;
	logic [15:0] pin_bits = '0;
	logic [7:0]  handler_id = '0;
	logic        enable_flag = 1'b0;
	logic [3:0]  line = '0;
	logic [31:0] now_ms = '0;
	logic [15:0] line_levels = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [1:0]  status;
	logic [3:0]  out_port;
	logic [3:0]  out_line;
	logic        pin_level;
	logic [7:0]  out_handler;
	logic        last;

	int mismatches;
	int owed;
	int status_seen;
	int dispatch_seen;

	// Idle rates in percent for the request side and the result side.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	// A change of hold_asked makes the result side hold off for a long stretch.
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int          sent = 0;
	int          window_ms = 20;
	logic [31:0] clock_ms = 32'd0;
	logic [3:0]  hot_lines [4];

	always #2 clk = ~clk;

	pin_interrupt_dispatch_table uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.port_id     (port_id),
		.pin_bits    (pin_bits),
		.handler_id  (handler_id),
		.enable_flag (enable_flag),
		.line        (line),
		.now_ms      (now_ms),
		.line_levels (line_levels),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.status      (status),
		.out_port    (out_port),
		.out_line    (out_line),
		.pin_level   (pin_level),
		.out_handler (out_handler),
		.last        (last)
	);

	dispatch_table_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.port_id       (port_id),
		.pin_bits      (pin_bits),
		.handler_id    (handler_id),
		.enable_flag   (enable_flag),
		.line          (line),
		.now_ms        (now_ms),
		.line_levels   (line_levels),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.status        (status),
		.out_port      (out_port),
		.out_line      (out_line),
		.pin_level     (pin_level),
		.out_handler   (out_handler),
		.last          (last),
		.mismatches    (mismatches),
		.owed          (owed),
		.status_seen   (status_seen),
		.dispatch_seen (dispatch_seen)
	);

	// Result side. A long hold-off is counted here, in cycles, so that the output
	// register fills, the block stops on its next result and stalls new requests.
	always @(posedge clk) begin
		if (hold_asked != hold_seen) begin
			hold_seen = hold_asked;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Offers one request and returns at the edge where it is taken. Valid is left
	// high on return so that back-to-back requests keep it high unless an idle gap is drawn.
	task automatic send_request(input cmd_t c, input logic [3:0] p, input logic [15:0] m,
			input logic [7:0] h, input logic en, input logic [3:0] ln,
			input logic [31:0] t, input logic [15:0] lv);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		port_id <= p;
		pin_bits <= m;
		handler_id <= h;
		enable_flag <= en;
		line <= ln;
		now_ms <= t;
		line_levels <= lv;
		do
			@(posedge clk);
		while (in_stall);
		sent++;
	endtask

	// Table requests carry random values in the event fields, which the block ignores.
	task automatic table_request(input cmd_t c, input logic [3:0] p, input logic [15:0] m,
			input logic [7:0] h, input logic en);
		send_request(c, p, m, h, en, 4'($urandom), $urandom, 16'($urandom));
	endtask

	task automatic line_event(input logic [3:0] ln, input logic [31:0] t, input logic [15:0] lv);
		send_request(CMD_EVENT, 4'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
			ln, t, lv);
	endtask

	// Stops offering and waits until every predicted result has come back. Events
	// that match nothing leave no trace on the output, so it then also waits for the
	// block to go idle before anything else happens.
	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		while (in_stall && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (30) @(posedge clk);
	endtask

	// Written only while the block is idle, i.e. after drain.
	task automatic set_window(input logic [15:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		window_ms = v;
	endtask

	// Mostly well-formed traffic on a few hot lines and the valid ports, so that
	// registrations collide, the table fills and events find several entries.
	// About one request in ten goes to any port or line, and one in twenty has an odd mask.
	task automatic random_request();
		int          pick;
		logic [3:0]  p;
		logic [3:0]  ln;
		logic [15:0] m;
		logic [31:0] t;
		pick = $urandom_range(99);
		ln = hot_lines[$urandom_range(3)];
		p = 4'($urandom_range(7));
		if ($urandom_range(9) == 0) begin
			p = 4'($urandom_range(15));
			ln = 4'($urandom_range(15));
		end
		m = 16'd1 << ln;
		if ($urandom_range(19) == 0)
			m = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
		if (pick < 35) begin
			table_request(CMD_REGISTER, p, m,
				($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 255)), 1'($urandom));
		end else if (pick < 50) begin
			table_request(CMD_UNREGISTER, p, m, 8'($urandom), 1'($urandom));
		end else if (pick < 62) begin
			table_request(CMD_ENABLE, p, m, 8'($urandom), 1'($urandom));
		end else begin
			// Most events clear the debounce window; some land inside it.
			if ($urandom_range(4) == 0)
				clock_ms = clock_ms + 32'($urandom_range(0, window_ms));
			else
				clock_ms = clock_ms + 32'(window_ms) + 32'($urandom_range(0, 500));
			t = ($urandom_range(29) == 0) ? $urandom : clock_ms;
			line_event(ln, t, 16'($urandom));
		end
	endtask

	// One traffic phase. At request twist_at either the result side holds off for
	// a long stretch while requests keep coming, or the sender pauses until the
	// block has handed back everything it owes.
	task automatic run_phase(input int count, input int tx_pct, input int rx_pct,
			input int twist_at, input bit hold_twist);
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		for (int i = 0; i < 4; i++)
			hot_lines[i] = 4'($urandom_range(15));
		for (int i = 0; i < count; i++) begin
			if (i == twist_at) begin
				if (hold_twist) begin
					hold_asked <= hold_asked + 1;
					tx_idle_pct = 0;
				end else begin
					drain();
				end
			end
			if (hold_twist && i == twist_at + 12)
				tx_idle_pct = tx_pct;
			random_request();
		end
	endtask

	initial begin : stimulus
		int fails;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_pct = 6;
		rx_idle_pct <= 55;

		// Right after reset every stamp is zero, so an early event is debounced.
		line_event(4'd0, 32'd5, 16'hFFFF);
		// Rejected registrations: no handler, port out of range, empty or multi-pin mask.
		table_request(CMD_REGISTER, 4'd0, 16'h0001, 8'd0, 1'b1);
		table_request(CMD_REGISTER, 4'd8, 16'h0001, 8'd1, 1'b0);
		table_request(CMD_REGISTER, 4'd15, 16'h8000, 8'hFF, 1'b1);
		table_request(CMD_REGISTER, 4'd0, 16'h0000, 8'd1, 1'b0);
		table_request(CMD_REGISTER, 4'd0, 16'hFFFF, 8'd1, 1'b1);
		// Good registrations, then a re-registration that swaps the handler in place.
		table_request(CMD_REGISTER, 4'd0, 16'h0001, 8'hFF, 1'b0);
		table_request(CMD_REGISTER, 4'd7, 16'h8000, 8'h01, 1'b0);
		table_request(CMD_REGISTER, 4'd3, 16'h0001, 8'h5A, 1'b0);
		table_request(CMD_REGISTER, 4'd0, 16'h0001, 8'h11, 1'b0);
		// Two dispatches in table order, then an event that is debounced across the wrap.
		line_event(4'd0, 32'hFFFF_FFFF, 16'hFFFF);
		line_event(4'd0, 32'd5, 16'hFFFF);
		// A disabled entry is skipped; the other one reports a low pin.
		table_request(CMD_ENABLE, 4'd0, 16'h0001, 8'd0, 1'b0);
		line_event(4'd0, 32'd100, 16'h0000);
		table_request(CMD_ENABLE, 4'd0, 16'h0001, 8'd0, 1'b1);
		// Set enable with a bad port, an empty mask, and on an entry that does not exist.
		table_request(CMD_ENABLE, 4'd9, 16'h0001, 8'd0, 1'b1);
		table_request(CMD_ENABLE, 4'd2, 16'h0000, 8'd0, 1'b1);
		table_request(CMD_ENABLE, 4'd2, 16'h0004, 8'd0, 1'b0);
		// Removing the first entry moves the last one into its slot.
		table_request(CMD_UNREGISTER, 4'd0, 16'h0001, 8'd0, 1'b0);
		table_request(CMD_UNREGISTER, 4'd5, 16'h0002, 8'd0, 1'b0);
		table_request(CMD_UNREGISTER, 4'd12, 16'h0001, 8'd0, 1'b0);
		line_event(4'd15, 32'h0000_0020, 16'h0080);
		// A line with no entries gives no result; a time far behind the stamp passes.
		line_event(4'd5, 32'd1000, 16'hFFFF);
		line_event(4'd0, 32'd0, 16'h0008);
		drain();

		clock_ms = 32'd5000;
		set_window(16'd0);
		run_phase(150, 6, 55, 60, 1'b1);
		drain();

		set_window(16'hFFFF);
		run_phase(150, 55, 6, 60, 1'b0);
		drain();

		// Start close to the top of the millisecond counter so that it wraps.
		clock_ms = 32'hFFFF_F000;
		set_window(16'($urandom_range(1, 400)));
		run_phase(150, 0, 0, -1, 1'b0);
		drain();

		fails = mismatches + owed;
		if (owed != 0)
			$display("%0d expected results never arrived", owed);
		$display("ran %0d requests, checked %0d status results and %0d dispatches",
			sent, status_seen, dispatch_seen);
		$display("with debounce windows of 20, 0, 65535 and %0d ms, a full table and counter wrap",
			window_ms);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Far beyond the slowest correct run, long stalls and hold-offs included.
	initial begin : watchdog
		#2000000;
		$display("run timed out");
		$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/pidt_pkg.sv
hw/rtl/pidt_table.sv
hw/rtl/pidt_match.sv
hw/rtl/pin_interrupt_dispatch_table.sv
dv/dispatch_table_checker.sv
dv/tb_pin_interrupt_dispatch_table.sv
